// ===== rtl/core/isbm_pkg.sv =====
package isbm_pkg;

	localparam int unsigned CMD_W       = 4;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned FULL_ADDR_W = 2 * BYTE_W;

	typedef logic [CMD_W-1:0]       cmd_t;
	typedef logic [BYTE_W-1:0]      byte_t;
	typedef logic [FULL_ADDR_W-1:0] full_addr_t;
	typedef logic [1:0]             byte_cnt_t;

	localparam cmd_t EV_ADDR_WRITE = 4'd0;
	localparam cmd_t EV_DATA_RX    = 4'd1;
	localparam cmd_t EV_ADDR_READ  = 4'd2;
	localparam cmd_t EV_TX_NACK    = 4'd3;
	localparam cmd_t EV_RX_NACK    = 4'd4;
	localparam cmd_t EV_STOP       = 4'd5;
	localparam cmd_t EV_ARB_LOST_A = 4'd6;
	localparam cmd_t EV_ARB_LOST_B = 4'd7;

	localparam byte_cnt_t BC_ADDR_HI = 2'd0;
	localparam byte_cnt_t BC_ADDR_LO = 2'd1;
	localparam byte_cnt_t BC_DATA    = 2'd2;

endpackage

// ===== rtl/core/isbm_ev_if.sv =====
interface isbm_ev_if;
	import isbm_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  command;
	byte_t rx_byte;

	modport source (output valid, command, rx_byte, input ready);
	modport sink (input valid, command, rx_byte, output ready);

endinterface

// ===== rtl/core/isbm_res_if.sv =====
interface isbm_res_if;
	import isbm_pkg::*;

	logic  valid;
	logic  ready;
	byte_t tx_byte;
	logic  tx_load;
	logic  bus_action;
	logic  mem_written;

	modport source (output valid, tx_byte, tx_load, bus_action, mem_written, input ready);
	modport sink (input valid, tx_byte, tx_load, bus_action, mem_written, output ready);

endinterface

// ===== rtl/core/i2c_slave_byte_memory_unit.sv =====
// Slave-side byte memory for an I2C link. Each bus event item gives exactly one result
// item, registered in stage 1 and then in stage 2, and a new item can be taken in every
// cycle unless the result side holds stage 2. Apart from that, the only exception is the
// low address byte of a write group: the 16-bit address is reduced modulo MEM_DEPTH by
// a reciprocal multiply followed by a multiply and subtract in the next cycle, so the
// item after it is held while that second step runs. After reset the memory is cleared
// one entry per cycle, and no item is accepted until that pass has finished.
module i2c_slave_byte_memory_unit #(
	parameter int unsigned MEM_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	isbm_ev_if.sink bus_ev,
	isbm_res_if.source result
);
	import isbm_pkg::*;

	localparam int unsigned AW     = $clog2(MEM_DEPTH);
	localparam int unsigned SHIFT  = FULL_ADDR_W + AW;
	localparam int unsigned PROD_W = 2 * FULL_ADDR_W + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + MEM_DEPTH - 1) / MEM_DEPTH;
	localparam logic [FULL_ADDR_W:0] RECIP = (FULL_ADDR_W + 1)'(RECIP_L);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

	byte_t byte_memory [MEM_DEPTH];

	logic            valid_s1;
	cmd_t            cmd_s1;
	byte_t           rx_s1;
	logic            valid_s2;
	logic            load_s2;
	logic            action_s2;
	logic            written_s2;
	byte_t           rdata_s2;
	logic [AW-1:0]   ptr_q;
	byte_cnt_t       cnt_q;
	byte_t           hi_q;
	logic            mod_busy_q;
	full_addr_t      full_q;
	full_addr_t      quot_q;
	logic            clr_busy_q;
	logic [AW-1:0]   clr_addr_q;

	logic            adv_s1;
	byte_cnt_t       cnt_nx;
	byte_t           hi_nx;
	logic            set_mod;
	logic            wr_en;
	logic            load;
	logic            action;
	full_addr_t      full_addr;
	logic [PROD_W-1:0] recip_prod;
	logic [PROD_W-1:0] quot_prod;
	logic [PROD_W-1:0] rem_full;
	logic [AW:0]     ptr_inc;
	logic [AW-1:0]   ptr_next_rd;

	assign adv_s1       = valid_s1 && (!valid_s2 || result.ready) && !mod_busy_q;
	assign bus_ev.ready = !clr_busy_q && (!valid_s1 || adv_s1);

	assign full_addr  = {hi_q, rx_s1};
	assign recip_prod = PROD_W'(full_addr) * PROD_W'(RECIP);
	assign quot_prod  = PROD_W'(quot_q) * PROD_W'(MEM_DEPTH);
	assign rem_full   = PROD_W'(full_q) - quot_prod;

	assign ptr_inc     = (AW + 1)'(ptr_q) + (AW + 1)'(1);
	assign ptr_next_rd = (ptr_q == LAST_ADDR) ? '0 : ptr_inc[AW-1:0];

	always_comb begin
		cnt_nx  = cnt_q;
		hi_nx   = hi_q;
		set_mod = 1'b0;
		wr_en   = 1'b0;
		load    = 1'b0;
		action  = 1'b0;
		unique case (cmd_s1) inside
			EV_ADDR_WRITE, EV_RX_NACK, EV_STOP: begin
				cnt_nx = BC_ADDR_HI;
			end
			EV_DATA_RX: begin
				case (cnt_q)
					BC_ADDR_LO: begin
						set_mod = 1'b1;
						cnt_nx  = BC_DATA;
					end
					BC_DATA: begin
						wr_en  = 1'b1;
						cnt_nx = BC_ADDR_HI;
					end
					default: begin
						hi_nx  = rx_s1;
						cnt_nx = BC_ADDR_LO;
					end
				endcase
			end
			EV_ADDR_READ: begin
				load = 1'b1;
			end
			EV_TX_NACK, EV_ARB_LOST_A, EV_ARB_LOST_B: begin
			end
			default: begin
				action = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			ptr_q      <= '0;
			cnt_q      <= BC_ADDR_HI;
			hi_q       <= '0;
			mod_busy_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (bus_ev.valid && bus_ev.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
			if (clr_busy_q) begin
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			mod_busy_q <= adv_s1 && set_mod;
			if (mod_busy_q) begin
				ptr_q <= rem_full[AW-1:0];
			end else if (adv_s1 && load) begin
				ptr_q <= ptr_next_rd;
			end
			if (adv_s1) begin
				cnt_q <= cnt_nx;
				hi_q  <= hi_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bus_ev.valid && bus_ev.ready) begin
			cmd_s1 <= bus_ev.command;
			rx_s1  <= bus_ev.rx_byte;
		end
		if (adv_s1) begin
			load_s2    <= load;
			action_s2  <= action;
			written_s2 <= wr_en;
			rdata_s2   <= byte_memory[ptr_q];
		end
		if (adv_s1 && set_mod) begin
			full_q <= full_addr;
			quot_q <= FULL_ADDR_W'(recip_prod >> SHIFT);
		end
		if (clr_busy_q) begin
			byte_memory[clr_addr_q] <= '0;
		end else if (adv_s1 && wr_en) begin
			byte_memory[ptr_q] <= rx_s1;
		end
	end

	assign result.valid       = valid_s2;
	assign result.tx_byte     = load_s2 ? rdata_s2 : '0;
	assign result.tx_load     = load_s2;
	assign result.bus_action  = action_s2;
	assign result.mem_written = written_s2;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import isbm_pkg::*;

	localparam int unsigned DEPTH      = 256;
	localparam int unsigned ITEM_COUNT = 1300;
	localparam int unsigned CALM_AFTER = 1100;
	localparam cmd_t        EV_OTHER   = 4'd8;
	localparam cmd_t        EV_UNLISTED = 4'd9;
	localparam cmd_t        EV_LAST    = 4'd15;

	typedef struct packed {
		cmd_t  command;
		byte_t rx_byte;
	} bus_event_t;

	typedef struct packed {
		byte_t tx_byte;
		logic  tx_load;
		logic  bus_action;
		logic  mem_written;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	isbm_ev_if  ev_ch ();
	isbm_res_if res_ch ();

	i2c_slave_byte_memory_unit #(
		.MEM_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.bus_ev(ev_ch.sink),
		.result(res_ch.source)
	);

	always #1 clk = ~clk;

	bus_event_t  pending_events[$];
	reply_t      expected_replies[$];
	byte_t       mirror_mem[DEPTH];
	int unsigned mirror_ptr;
	byte_cnt_t   mirror_count;
	byte_t       mirror_addr_hi;
	int unsigned queued_events;
	int unsigned accepted_events;
	int unsigned replies_seen;
	int unsigned failures;
	int unsigned src_gap;
	int unsigned snk_gap;

	function automatic bit idling_allowed(int unsigned progress);
		return (progress < CALM_AFTER) && ((progress / 150) % 3 != 2);
	endfunction

	// Works out the reply to one bus event and updates the mirrored slave state.
	function automatic void serve_bus_event(cmd_t command, byte_t rx_byte);
		reply_t     reply;
		full_addr_t full;
		reply = '0;
		case (command)
			EV_ADDR_WRITE, EV_RX_NACK, EV_STOP: begin
				mirror_count = BC_ADDR_HI;
			end
			EV_DATA_RX: begin
				if (mirror_count == BC_ADDR_LO) begin
					full = {mirror_addr_hi, rx_byte};
					mirror_ptr = full % DEPTH;
					mirror_count = BC_DATA;
				end else if (mirror_count == BC_DATA) begin
					mirror_mem[mirror_ptr % DEPTH] = rx_byte;
					reply.mem_written = 1'b1;
					mirror_count = BC_ADDR_HI;
				end else begin
					mirror_addr_hi = rx_byte;
					mirror_count = BC_ADDR_LO;
				end
			end
			EV_ADDR_READ: begin
				mirror_ptr = mirror_ptr % DEPTH;
				reply.tx_byte = mirror_mem[mirror_ptr];
				reply.tx_load = 1'b1;
				mirror_ptr = (mirror_ptr + 1) % DEPTH;
			end
			EV_TX_NACK, EV_ARB_LOST_A, EV_ARB_LOST_B: begin
			end
			default: begin
				reply.bus_action = 1'b1;
			end
		endcase
		expected_replies.push_back(reply);
	endfunction

	task automatic queue_event(cmd_t command, byte_t rx_byte);
		bus_event_t item;
		item.command = command;
		item.rx_byte = rx_byte;
		pending_events.push_back(item);
		queued_events++;
	endtask

	function automatic byte_t pick_low_address();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 15)) + 8'hF8;
		return 8'($urandom);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_event_t item;
		if (!arst_n) begin
			ev_ch.valid   <= 1'b0;
			ev_ch.command <= EV_ADDR_WRITE;
			ev_ch.rx_byte <= '0;
			src_gap = 0;
		end else begin
			if (ev_ch.valid && ev_ch.ready) begin
				serve_bus_event(ev_ch.command, ev_ch.rx_byte);
				accepted_events++;
			end
			if (!ev_ch.valid || ev_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					ev_ch.valid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					item = pending_events.pop_front();
					ev_ch.valid   <= 1'b1;
					ev_ch.command <= item.command;
					ev_ch.rx_byte <= item.rx_byte;
					if (idling_allowed(accepted_events) && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 19);
				end else begin
					ev_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					$error("unexpected result item: tx_byte %0h tx_load %0b bus_action %0b mem_written %0b",
						res_ch.tx_byte, res_ch.tx_load, res_ch.bus_action, res_ch.mem_written);
					failures++;
				end else begin
					want = expected_replies.pop_front();
					if (res_ch.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %0h, actual %0h", want.tx_byte, res_ch.tx_byte);
						failures++;
					end
					if (res_ch.tx_load !== want.tx_load) begin
						$error("tx_load: expected %0b, actual %0b", want.tx_load, res_ch.tx_load);
						failures++;
					end
					if (res_ch.bus_action !== want.bus_action) begin
						$error("bus_action: expected %0b, actual %0b", want.bus_action,
							res_ch.bus_action);
						failures++;
					end
					if (res_ch.mem_written !== want.mem_written) begin
						$error("mem_written: expected %0b, actual %0b", want.mem_written,
							res_ch.mem_written);
						failures++;
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (idling_allowed(replies_seen) && $urandom_range(0, 7) == 0)
					snk_gap = $urandom_range(1, 19);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("** i2c_slave_byte_memory_unit: FAILED **");
		$finish;
	end

	initial begin
		int unsigned kind;
		int unsigned n;
		arst_n = 1'b0;
		ev_ch.valid = 1'b0;
		ev_ch.command = EV_ADDR_WRITE;
		ev_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		foreach (mirror_mem[i])
			mirror_mem[i] = '0;
		mirror_ptr = 0;
		mirror_count = BC_ADDR_HI;
		mirror_addr_hi = '0;
		queued_events = 0;
		accepted_events = 0;
		replies_seen = 0;
		failures = 0;

		// Directed part: read before any write, the highest address with wrap of the
		// pointer, groups broken by a receive nack or a stop, and every event code of the package.
		queue_event(EV_ADDR_READ, 8'h00);
		queue_event(EV_ADDR_WRITE, 8'hFF);
		queue_event(EV_DATA_RX, 8'hFF);
		queue_event(EV_DATA_RX, 8'hFF);
		queue_event(EV_DATA_RX, 8'hA5);
		queue_event(EV_ADDR_READ, 8'hFF);
		queue_event(EV_ADDR_READ, 8'h00);
		queue_event(EV_DATA_RX, 8'h12);
		queue_event(EV_RX_NACK, 8'hFF);
		queue_event(EV_DATA_RX, 8'h00);
		queue_event(EV_DATA_RX, 8'h00);
		queue_event(EV_STOP, 8'h00);
		queue_event(EV_ADDR_READ, 8'h00);
		queue_event(EV_DATA_RX, 8'h12);
		queue_event(EV_TX_NACK, 8'hFF);
		queue_event(EV_ARB_LOST_A, 8'h00);
		queue_event(EV_DATA_RX, 8'h34);
		queue_event(EV_ARB_LOST_B, 8'hFF);
		queue_event(EV_DATA_RX, 8'hFF);
		queue_event(EV_OTHER, 8'h00);
		queue_event(EV_LAST, 8'hFF);
		queue_event(EV_UNLISTED, 8'h5A);
		queue_event(EV_ADDR_READ, 8'h00);
		queue_event(EV_ADDR_READ, 8'h00);

		while (queued_events < ITEM_COUNT) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				queue_event(EV_ADDR_WRITE, 8'($urandom));
				n = $urandom_range(1, 4);
				repeat (n) begin
					queue_event(EV_DATA_RX, 8'($urandom));
					queue_event(EV_DATA_RX, pick_low_address());
					queue_event(EV_DATA_RX, 8'($urandom));
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 2))
						queue_event(EV_DATA_RX, 8'($urandom));
					if ($urandom_range(0, 1) == 0)
						queue_event(EV_RX_NACK, 8'($urandom));
				end
				queue_event(EV_STOP, 8'($urandom));
			end else if (kind < 80) begin
				queue_event(EV_ADDR_WRITE, 8'($urandom));
				queue_event(EV_DATA_RX, 8'($urandom));
				queue_event(EV_DATA_RX, pick_low_address());
				queue_event(EV_STOP, 8'($urandom));
				repeat ($urandom_range(1, 6))
					queue_event(EV_ADDR_READ, 8'($urandom));
				queue_event(EV_TX_NACK, 8'($urandom));
				queue_event(EV_STOP, 8'($urandom));
			end else if (kind < 90) begin
				queue_event($urandom_range(0, 1) ? EV_ARB_LOST_A : EV_ARB_LOST_B, 8'($urandom));
				queue_event(cmd_t'($urandom_range(EV_OTHER, EV_LAST)), 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 5))
					queue_event(cmd_t'($urandom_range(0, EV_LAST)), 8'($urandom));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() != 0 || ev_ch.valid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0)
			$display("** i2c_slave_byte_memory_unit: PASSED **");
		else
			$display("** i2c_slave_byte_memory_unit: FAILED **");
		$finish;
	end

endmodule
